// File: sv/dss_pkg.sv
// Shared types and constants for the dual stack shared store unit.
// Used by the front, back and top modules; depends on nothing else.
`default_nettype none

package dss_pkg;

    // Default number of 32-bit entries in the shared store.
    localparam int STORE_DEPTH_DEF = 16;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_DEPTH = 2;

    // Depth of the result queue at the output; a power of two.
    localparam int OUT_DEPTH = 4;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_DUMP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DUMP = 1'b1
    } bk_state_t;

    // One decoded request as it travels from the front to the back part.
    typedef struct packed {
        op_t                op;
        logic               is_b;
        logic [DATA_W-1:0]  value;
    } cmd_t;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        status_t            status;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// File: sv/dual_stack_shared_store_unit.sv
// Top level of the dual stack shared store unit.
// Depends on dss_pkg, dss_front, dss_back (which holds the dss_ram store).
//
// Two stacks live in one store of STORE_DEPTH 32-bit entries. Stack A grows
// upward from entry 0 and stack B grows downward from the top entry.
// Requests enter through a queue-like port: an item is taken at a clock edge
// with push high and full low. Results leave through a second queue-like
// port: the oldest result sits on data, status and last while empty is low,
// and it is taken at an edge with pop high.
// Push, pop and peek give one result each; a dump gives one result per
// element from the top of the stack to its base, with last set on the final
// one, and a dump of an empty stack gives one result with status empty.
// The first result of a request passes from the command queue through the
// result stage, which lines up with the registered store read, into the
// output queue, from which it shows on the result ports.
// The back part issues one result per cycle while the output queue has
// room, so push, pop and peek run at one item per cycle, and a dump holds
// the back part until it has issued every element of the stack.
// When the receiver stops popping, the output queue fills, the back part
// pauses, and the command queue then raises full. After reset both stacks
// are empty and both queues are empty; store contents are undefined until
// pushed, and no unwritten entry's contents ever reach the result ports.
`default_nettype none

module dual_stack_shared_store_unit #(
    parameter int STORE_DEPTH = dss_pkg::STORE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] push_value,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      data,
    output logic [1:0]              status,
    output logic                    last
);

    import dss_pkg::*;

    // Decoded command handed from the front part to the back part.
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    // The front part decodes each item and buffers it so that a stalled
    // back part does not block acceptance right away.
    dss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .push_value (push_value),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // The back part owns the stack counts, the store and the result queue.
    dss_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .data      (data),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire

// File: sv/dss_ram.sv
// Generic simple dual-port RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/dss_front.sv
// Front part: accepts request items, decodes the action and queues commands.
// Depends on dss_pkg.
`default_nettype none

module dss_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [2:0]            action,
    input  wire logic signed [31:0]    push_value,
    output logic                       cmd_valid,
    input  wire logic                  cmd_ready,
    output dss_pkg::cmd_t              cmd
);

    import dss_pkg::*;

    localparam int QAW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int QCW = $clog2(CMD_DEPTH + 1);

    cmd_t           q_reg [CMD_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic           do_wr, do_rd;
    cmd_t           dec;

    // The low two action bits select the operation, the top bit the stack.
    always_comb
    begin
        dec.op    = op_t'(action[1:0]);
        dec.is_b  = action[2];
        dec.value = push_value;
    end

    assign full      = (cnt_reg == QCW'(CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// File: sv/dss_back.sv
// Back part: executes commands against the shared store and queues results.
// Depends on dss_pkg and dss_ram.
`default_nettype none

module dss_back #(
    parameter int STORE_DEPTH = dss_pkg::STORE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire dss_pkg::cmd_t      cmd,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      data,
    output logic [1:0]              status,
    output logic                    last
);

    import dss_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int OAW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    bk_state_t      state_reg, state_next;
    logic [CW-1:0]  cnt_a_reg, cnt_a_next;
    logic [CW-1:0]  cnt_b_reg, cnt_b_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic           dump_b_reg, dump_b_next;

    // Result stage: lines up with the registered RAM read.
    logic           s1_valid_reg, s1_valid_next;
    logic           s1_use_ram_reg, s1_use_ram_next;
    status_t        s1_status_reg, s1_status_next;
    logic           s1_last_reg, s1_last_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [31:0]    ram_rdata;

    res_t           oq_reg [OUT_DEPTH];
    logic [OAW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OCW-1:0] oq_cnt_reg, oq_cnt_next;
    logic           oq_wr, oq_rd;
    res_t           oq_in;

    logic           space;
    logic           store_full;
    logic [CW-1:0]  sel_cnt;
    logic [AW-1:0]  top_a, top_b, sel_top;
    logic [AW-1:0]  push_a, push_b;

    dss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Issue only when the output queue can hold this result and the one in flight.
    assign space = ((OCW + 1)'(oq_cnt_reg) + (OCW + 1)'(s1_valid_reg)) < (OCW + 1)'(OUT_DEPTH);

    assign store_full = ((CW + 1)'(cnt_a_reg) + (CW + 1)'(cnt_b_reg)) == (CW + 1)'(STORE_DEPTH);
    assign top_a      = AW'(cnt_a_reg - 1'b1);
    assign top_b      = AW'(CW'(STORE_DEPTH) - cnt_b_reg);
    assign push_a     = AW'(cnt_a_reg);
    assign push_b     = AW'(CW'(STORE_DEPTH - 1) - cnt_b_reg);
    assign sel_cnt    = cmd.is_b ? cnt_b_reg : cnt_a_reg;
    assign sel_top    = cmd.is_b ? top_b : top_a;

    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        dump_b_next     = dump_b_reg;
        cmd_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = push_a;
        ram_raddr       = sel_top;
        s1_valid_next   = 1'b0;
        s1_use_ram_next = 1'b0;
        s1_status_next  = ST_OK;
        s1_last_next    = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && space)
                begin
                    cmd_ready     = 1'b1;
                    s1_valid_next = 1'b1;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            if (store_full)
                            begin
                                s1_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (cmd.is_b)
                                begin
                                    ram_waddr  = push_b;
                                    cnt_b_next = cnt_b_reg + 1'b1;
                                end
                                else
                                begin
                                    cnt_a_next = cnt_a_reg + 1'b1;
                                end
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (sel_cnt == '0)
                            begin
                                s1_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                s1_use_ram_next = 1'b1;
                                if (cmd.op == OP_POP)
                                begin
                                    if (cmd.is_b)
                                    begin
                                        cnt_b_next = cnt_b_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        cnt_a_next = cnt_a_reg - 1'b1;
                                    end
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (sel_cnt == '0)
                            begin
                                s1_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                s1_use_ram_next = 1'b1;
                                if (sel_cnt != CW'(1))
                                begin
                                    // More elements follow: walk toward the base.
                                    s1_last_next = 1'b0;
                                    state_next   = BK_DUMP;
                                    dump_b_next  = cmd.is_b;
                                    rem_next     = sel_cnt - 1'b1;
                                    idx_next     = cmd.is_b ? sel_top + 1'b1 : sel_top - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            s1_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            BK_DUMP:
            begin
                ram_raddr = idx_reg;
                if (space)
                begin
                    s1_valid_next   = 1'b1;
                    s1_use_ram_next = 1'b1;
                    s1_last_next    = (rem_reg == CW'(1));
                    idx_next        = dump_b_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                    rem_next        = rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        dump_b_reg     <= dump_b_next;
        s1_use_ram_reg <= s1_use_ram_next;
        s1_status_reg  <= s1_status_next;
        s1_last_reg    <= s1_last_next;
    end

    // Output queue.
    assign oq_in.data   = s1_use_ram_reg ? ram_rdata : '0;
    assign oq_in.status = s1_status_reg;
    assign oq_in.last   = s1_last_reg;
    assign oq_wr        = s1_valid_reg;
    assign empty        = (oq_cnt_reg == '0);
    assign oq_rd        = pop && !empty;

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (oq_wr && !oq_rd)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (oq_rd && !oq_wr)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_cnt_reg <= oq_cnt_next;
            if (oq_wr)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_rd)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_reg[oq_wr_reg] <= oq_in;
        end
    end

    assign data   = oq_reg[oq_rd_reg].data;
    assign status = oq_reg[oq_rd_reg].status;
    assign last   = oq_reg[oq_rd_reg].last;

endmodule

`default_nettype wire

// File: dv/dss_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the dual stack shared store testbench: a predictor of both stacks
// and the queue of results that it expects. Depends on dss_pkg for types and codes.

package dss_tb_pkg;

    import dss_pkg::*;

    localparam int MODEL_DEPTH = STORE_DEPTH_DEF;
    localparam int MAX_REPORTS = 50;

    class stack_scoreboard;

        logic [DATA_W-1:0] store_copy [MODEL_DEPTH];
        int unsigned       depth_a;
        int unsigned       depth_b;
        res_t              result_q [$];
        int unsigned       mismatch_count;

        function new();
            depth_a        = 0;
            depth_b        = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending_count();
            return result_q.size();
        endfunction

        function void add_result(logic [DATA_W-1:0] d, status_t s, logic l);
            res_t r;
            r.data   = d;
            r.status = s;
            r.last   = l;
            result_q.push_back(r);
        endfunction

        // Updates both stacks for one accepted item and queues what it yields.
        function void note_request(logic [2:0] act, logic [DATA_W-1:0] val);
            op_t         op;
            logic        is_b;
            int unsigned held;
            int unsigned top;
            op   = op_t'(act[1:0]);
            is_b = act[2];
            held = is_b ? depth_b : depth_a;
            if (op == OP_PUSH) begin
                if (depth_a + depth_b >= MODEL_DEPTH) begin
                    add_result('0, ST_OVERFLOW, 1'b1);
                end
                else begin
                    if (is_b) begin
                        store_copy[MODEL_DEPTH - 1 - depth_b] = val;
                        depth_b++;
                    end
                    else begin
                        store_copy[depth_a] = val;
                        depth_a++;
                    end
                    add_result('0, ST_OK, 1'b1);
                end
            end
            else if (held == 0) begin
                add_result('0, ST_EMPTY, 1'b1);
            end
            else begin
                top = is_b ? MODEL_DEPTH - depth_b : depth_a - 1;
                if (op == OP_DUMP) begin
                    // Stack B's base is the top entry, so its dump walks upward.
                    for (int i = 0; i < held; i++) begin
                        add_result(store_copy[is_b ? top + i : top - i], ST_OK,
                                   (i == held - 1));
                    end
                end
                else begin
                    add_result(store_copy[top], ST_OK, 1'b1);
                    if (op == OP_POP) begin
                        if (is_b) depth_b--;
                        else depth_a--;
                    end
                end
            end
        endfunction

        task report(string what);
            if (mismatch_count < MAX_REPORTS) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
            mismatch_count++;
        endtask

        task check_result(logic [DATA_W-1:0] d, logic [1:0] s, logic l);
            res_t want;
            if (result_q.size() == 0) begin
                report($sformatf("unexpected result data=%h status=%0d last=%0d", d, s, l));
            end
            else begin
                want = result_q.pop_front();
                if (d !== want.data) begin
                    report($sformatf("data %h, expected %h", d, want.data));
                end
                if (s !== want.status) begin
                    report($sformatf("status %0d, expected %0d", s, want.status));
                end
                if (l !== want.last) begin
                    report($sformatf("last %0d, expected %0d", l, want.last));
                end
            end
        endtask

    endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Top level of the testbench for dual_stack_shared_store_unit: clock, reset,
// item driver, result receiver and run control. Depends on dss_pkg and dss_tb_pkg.

module tb_top;

    import dss_pkg::*;
    import dss_tb_pkg::*;

    // The whole run normally ends well inside this time; it only catches a hang.
    localparam int TIMEOUT_NS = 1_000_000;
    // Cycles allowed after the last expected result for stray results to show up.
    localparam int DRAIN_TAIL = 12;
    // Length of the stretch in which the receiver refuses every result.
    localparam int LONG_HOLD  = 300;

    localparam logic SIDE_A = 1'b0;
    localparam logic SIDE_B = 1'b1;

    // Character of a stretch of random items: leaning toward pushes, toward
    // pops, or an even mix.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               push       = 1'b0;
    logic [2:0]         action     = '0;
    logic signed [31:0] push_value = '0;
    logic               pop        = 1'b0;
    logic               full;
    logic               empty;
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;

    // Idle rates in percent for each side, and the receiver's hold-off counter.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          rx_hold_cycles = 0;

    stack_scoreboard sb;

    dual_stack_shared_store_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .push_value (push_value),
        .empty      (empty),
        .pop        (pop),
        .data       (data),
        .status     (status),
        .last       (last)
    );

    always #1 clk = ~clk;

    function automatic logic [2:0] make_action(logic is_b, op_t op);
        return {is_b, op};
    endfunction

    // Push values lean on the corners of the signed range now and then, so that
    // sign and carry-like patterns show up in the store, not only random words.
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4) return 32'h7fff_ffff;
        else if (roll < 8) return 32'h8000_0000;
        else if (roll < 11) return 32'h0000_0000;
        else if (roll < 14) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Offers one item, idling first at the current sender rate, and holds it
    // until the block takes it. The task starts and ends on a falling edge, and
    // push is left high so that back-to-back items need no extra edge.
    task automatic send_request(input logic [2:0] act, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        action     <= act;
        push_value <= val;
        do begin
            @(posedge clk);
        end while (full);
        sb.note_request(act, val);
        @(negedge clk);
    endtask

    // Stops offering items until every expected result has been taken. The
    // trailing edge keeps the drop and any later raise of push in separate steps.
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending_count() != 0) begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Short directed opening: empty pop, peek and dumps first, then the store filled
    // from both ends with corner values, overflow on both sides, and the
    // remaining operations, starting on the full store, including dumps of both stacks.
    task automatic run_directed();
        logic [31:0] corner_a [4];
        logic [31:0] corner_b [4];
        corner_a = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h5a5a_5a5a};
        corner_b = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_fffe, 32'ha5a5_a5a5};
        send_request(make_action(SIDE_A, OP_POP),  $urandom);
        send_request(make_action(SIDE_B, OP_PEEK), $urandom);
        send_request(make_action(SIDE_A, OP_DUMP), $urandom);
        send_request(make_action(SIDE_B, OP_DUMP), $urandom);
        for (int i = 0; i < MODEL_DEPTH / 2; i++) begin
            send_request(make_action(SIDE_A, OP_PUSH), (i < 4) ? corner_a[i] : $urandom);
            send_request(make_action(SIDE_B, OP_PUSH), (i < 4) ? corner_b[i] : $urandom);
        end
        // The tops now meet, so both of these must be refused.
        send_request(make_action(SIDE_A, OP_PUSH), $urandom);
        send_request(make_action(SIDE_B, OP_PUSH), $urandom);
        send_request(make_action(SIDE_A, OP_PEEK), $urandom);
        send_request(make_action(SIDE_B, OP_POP),  $urandom);
        send_request(make_action(SIDE_A, OP_DUMP), $urandom);
        send_request(make_action(SIDE_B, OP_DUMP), $urandom);
    endtask

    // Random items in stretches of sixteen. Fill stretches drive the stacks into
    // overflow, drain stretches run them down into underflow, and even ones
    // wander in between; dumps come often enough to give long result bursts.
    task automatic run_random(input int count);
        mix_t        mix;
        int unsigned roll;
        int unsigned push_cut;
        int unsigned pop_cut;
        op_t         op;
        mix = MIX_EVEN;
        for (int i = 0; i < count; i++) begin
            if (i % 16 == 0) begin
                mix = mix_t'($urandom_range(2));
            end
            case (mix)
                MIX_FILL:  begin push_cut = 70; pop_cut = 80; end
                MIX_DRAIN: begin push_cut = 20; pop_cut = 65; end
                default:   begin push_cut = 40; pop_cut = 65; end
            endcase
            roll = $urandom_range(99);
            if (roll < push_cut) op = OP_PUSH;
            else if (roll < pop_cut) op = OP_POP;
            else if (roll < pop_cut + (100 - pop_cut) / 2) op = OP_PEEK;
            else op = OP_DUMP;
            send_request(make_action(logic'($urandom_range(1)), op), pick_value());
        end
    endtask

    // Receiver: decides pop on each falling edge. A hold-off set by the run
    // control is counted down here, by one on each edge, with pop low throughout.
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                pop <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every result taken at a rising edge is checked against the oldest
    // expectation; the values read here are those that stood before the edge.
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            sb.check_result(data, status, last);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First phase: the sender idles rarely and the receiver mostly stalls,
        // so results back up into the output queue.
        send_idle_pct = 13;
        recv_idle_pct = 75;
        run_directed();
        run_random(130);

        // A long hold-off on the receiver while items keep coming: the result
        // queue fills, the back part pauses, and full must push back on us.
        rx_hold_cycles = LONG_HOLD;
        run_random(40);

        // The sender pauses until the block has handed over everything.
        wait_drained();

        // Second phase: roles swapped, so the block often runs empty.
        send_idle_pct = 75;
        recv_idle_pct = 13;
        run_random(120);

        // Third phase: both sides at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(95);

        wait_drained();
        repeat (DRAIN_TAIL) @(negedge clk);

        if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dss_pkg.sv
sv/dss_ram.sv
sv/dss_front.sv
sv/dss_back.sv
sv/dual_stack_shared_store_unit.sv
dv/dss_tb_pkg.sv
dv/tb_top.sv
